// File: rtl/pcmc_pkg.sv
// Shared constants for the periodic cell membership counter.
// Holds default widths and configuration register indexes; no dependencies.
`timescale 1ns / 1ps

package pcmc_pkg;

  localparam int COORD_BITS_DEF = 24;
  localparam int COUNT_BITS_DEF = 32;

  // Configuration register indexes.
  localparam int CFG_ADDR_BITS = 3;
  typedef logic [CFG_ADDR_BITS-1:0] cfg_addr_t;

  localparam cfg_addr_t REG_CENTER_X          = 3'd0;
  localparam cfg_addr_t REG_CENTER_Y          = 3'd1;
  localparam cfg_addr_t REG_CENTER_Z          = 3'd2;
  localparam cfg_addr_t REG_HALF_WIDTH        = 3'd3;
  localparam cfg_addr_t REG_HALF_BUFFER_WIDTH = 3'd4;

  localparam int NUM_AXES = 3;

endpackage

// File: rtl/periodic_cell_membership_counter_unit.sv
// Periodic cell membership counter: top level with input register, classifier,
// accumulators and result register.
// Depends on pcmc_pkg for default widths and register indexes.
`timescale 1ns / 1ps

//  Channel  Ports                          Carries
//  input    in_tvalid/tready/tdata/tlast   one particle position; tlast ends a pass
//  result   out_tvalid/tready/tdata        counts and bounding box, once per pass
//  config   cfg_we/cfg_addr/cfg_wdata      cell center and half widths
//
// One particle request is taken every cycle while no last particle is stalled;
// the input register feeds a single stage of subtract, compare and accumulate
// logic. The result register loads a result as its pass's last particle leaves.
// Only a last particle waits on a full result register that is stalled;
// other particles keep flowing while a result is pending.
// Reset restores the register defaults and clears counts and the box.

module periodic_cell_membership_counter_unit #(
  parameter int COORD_BITS = pcmc_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = pcmc_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // Fields from bit 0: pos_x, pos_y, pos_z, zero padding.
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]     in_tdata,
  input  logic                                  in_tlast,

  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // Fields from bit 0: main_count, buffer_count, min_dx, max_dx, min_dy,
  // max_dy, min_dz, max_dz, zero padding.
  output logic [((2*COUNT_BITS+6*COORD_BITS+7)/8)*8-1:0] out_tdata,

  input  logic                                  cfg_we,
  input  pcmc_pkg::cfg_addr_t                   cfg_addr,
  input  logic [COORD_BITS-1:0]                 cfg_wdata
);

  localparam int NA       = pcmc_pkg::NUM_AXES;
  localparam int OUT_BITS = ((2*COUNT_BITS+6*COORD_BITS+7)/8)*8;
  localparam int OUT_USED = 2*COUNT_BITS + 6*COORD_BITS;

  localparam logic [COORD_BITS-1:0] CENTER_RST = COORD_BITS'(64'd1 << (COORD_BITS-2));
  localparam longint unsigned HBW_WIDE       = (64'd7 << COORD_BITS) / 20;
  localparam logic [COORD_BITS-1:0] HBW_RST  = COORD_BITS'(HBW_WIDE);
  localparam logic signed [COORD_BITS-1:0] SMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SMIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] CNT_FULL = {COUNT_BITS{1'b1}};

  // Configuration registers.
  logic [COORD_BITS-1:0] center_r [NA];
  logic [COORD_BITS-1:0] half_width_r;
  logic [COORD_BITS-1:0] half_buf_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) center_r[a] <= CENTER_RST;
      half_width_r     <= CENTER_RST;
      half_buf_width_r <= HBW_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        pcmc_pkg::REG_CENTER_X:          center_r[0]      <= cfg_wdata;
        pcmc_pkg::REG_CENTER_Y:          center_r[1]      <= cfg_wdata;
        pcmc_pkg::REG_CENTER_Z:          center_r[2]      <= cfg_wdata;
        pcmc_pkg::REG_HALF_WIDTH:        half_width_r     <= cfg_wdata;
        pcmc_pkg::REG_HALF_BUFFER_WIDTH: half_buf_width_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  logic                  a_valid_r;
  logic                  a_last_r;
  logic [COORD_BITS-1:0] a_pos_r [NA];
  logic                  a_adv;

  // A last particle may only leave once the result register is free.
  assign a_adv     = a_valid_r && (!a_last_r || !out_tvalid || out_tready);
  assign in_tready = !a_valid_r || a_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_tready) begin
      a_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      a_last_r <= in_tlast;
      for (int a = 0; a < NA; a++) begin
        a_pos_r[a] <= in_tdata[a*COORD_BITS +: COORD_BITS];
      end
    end
  end

  // Classifier: the modular difference read as two's complement is the wrapped offset.
  logic signed [COORD_BITS-1:0] off    [NA];
  logic        [COORD_BITS-1:0] mag    [NA];
  logic                         in_main;
  logic                         in_buf;

  always_comb begin
    in_main = 1'b1;
    in_buf  = 1'b1;
    for (int a = 0; a < NA; a++) begin
      off[a] = $signed(a_pos_r[a] - center_r[a]);
      mag[a] = off[a][COORD_BITS-1] ? (~a_pos_r[a] + center_r[a] + 1'b1)
                                    : $unsigned(off[a]);
      if (!(mag[a] < half_buf_width_r)) in_buf = 1'b0;
      if (!(mag[a] <= half_width_r))    in_main = 1'b0;
    end
  end

  // Accumulators.
  logic [COUNT_BITS-1:0]        main_cnt_r, main_cnt_nxt;
  logic [COUNT_BITS-1:0]        buf_cnt_r,  buf_cnt_nxt;
  logic signed [COORD_BITS-1:0] box_min_r [NA];
  logic signed [COORD_BITS-1:0] box_max_r [NA];
  logic signed [COORD_BITS-1:0] box_min_nxt [NA];
  logic signed [COORD_BITS-1:0] box_max_nxt [NA];

  always_comb begin
    main_cnt_nxt = main_cnt_r;
    buf_cnt_nxt  = buf_cnt_r;
    if (in_buf && buf_cnt_r != CNT_FULL)   buf_cnt_nxt  = buf_cnt_r + 1'b1;
    if (in_main && main_cnt_r != CNT_FULL) main_cnt_nxt = main_cnt_r + 1'b1;
    for (int a = 0; a < NA; a++) begin
      box_min_nxt[a] = box_min_r[a];
      box_max_nxt[a] = box_max_r[a];
      if (in_main && off[a] < box_min_r[a]) box_min_nxt[a] = off[a];
      if (in_main && off[a] > box_max_r[a]) box_max_nxt[a] = off[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_cnt_r <= '0;
      buf_cnt_r  <= '0;
      for (int a = 0; a < NA; a++) begin
        box_min_r[a] <= SMAX;
        box_max_r[a] <= SMIN;
      end
    end else if (a_adv) begin
      if (a_last_r) begin
        main_cnt_r <= '0;
        buf_cnt_r  <= '0;
        for (int a = 0; a < NA; a++) begin
          box_min_r[a] <= SMAX;
          box_max_r[a] <= SMIN;
        end
      end else begin
        main_cnt_r <= main_cnt_nxt;
        buf_cnt_r  <= buf_cnt_nxt;
        for (int a = 0; a < NA; a++) begin
          box_min_r[a] <= box_min_nxt[a];
          box_max_r[a] <= box_max_nxt[a];
        end
      end
    end
  end

  // Result register.
  logic                    out_valid_r;
  logic [OUT_USED-1:0]     out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (a_adv && a_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_last_r) begin
      out_data_r[0 +: COUNT_BITS]          <= main_cnt_nxt;
      out_data_r[COUNT_BITS +: COUNT_BITS] <= buf_cnt_nxt;
      for (int a = 0; a < NA; a++) begin
        out_data_r[2*COUNT_BITS + (2*a)*COORD_BITS +: COORD_BITS]   <= box_min_nxt[a];
        out_data_r[2*COUNT_BITS + (2*a+1)*COORD_BITS +: COORD_BITS] <= box_max_nxt[a];
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_BITS'(out_data_r);

`ifndef ASSERT_OFF
  // A result is only ever raised by a last particle leaving the input register.
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(a_adv && a_last_r))
    else $error("result raised without a last particle");

  // The pass state is cleared right after a result is loaded.
  a_clear_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_adv && a_last_r) |=> (main_cnt_r == '0 && buf_cnt_r == '0))
    else $error("counters not cleared after a result");

  // Once a main particle has been seen the box is well ordered on every axis.
  a_box_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (main_cnt_r != '0) |-> (box_min_r[0] <= box_max_r[0] &&
                            box_min_r[1] <= box_max_r[1] &&
                            box_min_r[2] <= box_max_r[2]))
    else $error("bounding box inverted");

  // A pending last particle must block new input while the result is stalled.
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_last_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while a last particle is blocked");
`endif

endmodule

// File: test/pcmc_result_checker.sv
// Result checker for the periodic cell membership counter.
// Watches the particle, result and register write channels, predicts each pass
// result from its own cell model and compares field by field. Depends on pcmc_pkg.
`timescale 1ns / 1ps

module pcmc_result_checker #(
  parameter int CW = pcmc_pkg::COORD_BITS_DEF,
  parameter int NW = pcmc_pkg::COUNT_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  input  logic                                in_tready,
  input  logic [((3*CW+7)/8)*8-1:0]           in_tdata,
  input  logic                                in_tlast,
  input  logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic [((2*NW+6*CW+7)/8)*8-1:0]      out_tdata,
  input  logic                                cfg_we,
  input  pcmc_pkg::cfg_addr_t                 cfg_addr,
  input  logic [CW-1:0]                       cfg_wdata,
  output int                                  failures,
  output int                                  outstanding
);

  localparam int OUT_W = ((2*NW+6*CW+7)/8)*8;
  localparam logic [CW-1:0] MOST_POS = {1'b0, {(CW-1){1'b1}}};
  localparam logic [CW-1:0] MOST_NEG = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] DEF_CENTER = CW'(1) << (CW-2);
  localparam logic [CW-1:0] DEF_HALF_BUF = CW'((64'd7 << CW) / 20);

  typedef struct packed {
    logic [NW-1:0]      main_count;
    logic [NW-1:0]      buffer_count;
    logic [2:0][CW-1:0] box_lo;
    logic [2:0][CW-1:0] box_hi;
  } cell_tally_t;

  logic [2:0][CW-1:0] center;
  logic [CW-1:0]      half_w;
  logic [CW-1:0]      half_bw;
  cell_tally_t        tally;
  cell_tally_t        pending_tallies[$];
  int                 results_seen;
  string              axis_name[3] = '{"x", "y", "z"};

  function automatic cell_tally_t cleared_tally();
    cell_tally_t t;
    t.main_count = '0;
    t.buffer_count = '0;
    for (int a = 0; a < 3; a++) begin
      t.box_lo[a] = MOST_POS;
      t.box_hi[a] = MOST_NEG;
    end
    return t;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    failures++;
  endtask

  // Offsets are taken modulo the box and read as two's complement, so an
  // offset of exactly one half lands on the most negative value.
  task automatic absorb_particle(input logic [3*CW-1:0] pos, input logic last);
    logic [CW-1:0] off [3];
    logic [CW-1:0] mag;
    bit            in_main;
    bit            in_buf;
    in_main = 1'b1;
    in_buf = 1'b1;
    for (int a = 0; a < 3; a++) begin
      off[a] = pos[a*CW +: CW] - center[a];
      mag = off[a][CW-1] ? -off[a] : off[a];
      if (!(mag < half_bw)) in_buf = 1'b0;
      if (mag > half_w) in_main = 1'b0;
    end
    if (in_buf && tally.buffer_count != '1)
      tally.buffer_count = tally.buffer_count + 1'b1;
    if (in_main) begin
      if (tally.main_count != '1)
        tally.main_count = tally.main_count + 1'b1;
      for (int a = 0; a < 3; a++) begin
        if ($signed(off[a]) < $signed(tally.box_lo[a])) tally.box_lo[a] = off[a];
        if ($signed(off[a]) > $signed(tally.box_hi[a])) tally.box_hi[a] = off[a];
      end
    end
    if (last) begin
      pending_tallies.push_back(tally);
      tally = cleared_tally();
    end
  endtask

  task automatic check_result(input logic [OUT_W-1:0] data);
    cell_tally_t   want;
    logic [CW-1:0] got_lo;
    logic [CW-1:0] got_hi;
    if (pending_tallies.size() == 0) begin
      flag_mismatch($sformatf("result %0d arrived with no pass pending", results_seen));
      return;
    end
    want = pending_tallies.pop_front();
    if (data[NW-1:0] != want.main_count)
      flag_mismatch($sformatf("result %0d main_count: got %0d, expected %0d",
                              results_seen, data[NW-1:0], want.main_count));
    if (data[2*NW-1:NW] != want.buffer_count)
      flag_mismatch($sformatf("result %0d buffer_count: got %0d, expected %0d",
                              results_seen, data[2*NW-1:NW], want.buffer_count));
    for (int a = 0; a < 3; a++) begin
      got_lo = data[2*NW + 2*a*CW +: CW];
      got_hi = data[2*NW + (2*a+1)*CW +: CW];
      if (got_lo != want.box_lo[a])
        flag_mismatch($sformatf("result %0d min_d%s: got %0d, expected %0d", results_seen,
                                axis_name[a], $signed(got_lo), $signed(want.box_lo[a])));
      if (got_hi != want.box_hi[a])
        flag_mismatch($sformatf("result %0d max_d%s: got %0d, expected %0d", results_seen,
                                axis_name[a], $signed(got_hi), $signed(want.box_hi[a])));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) center[a] = DEF_CENTER;
      half_w = DEF_CENTER;
      half_bw = DEF_HALF_BUF;
      tally = cleared_tally();
      pending_tallies.delete();
      failures = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pcmc_pkg::REG_CENTER_X:          center[0] = cfg_wdata;
          pcmc_pkg::REG_CENTER_Y:          center[1] = cfg_wdata;
          pcmc_pkg::REG_CENTER_Z:          center[2] = cfg_wdata;
          pcmc_pkg::REG_HALF_WIDTH:        half_w = cfg_wdata;
          pcmc_pkg::REG_HALF_BUFFER_WIDTH: half_bw = cfg_wdata;
          default: ;
        endcase
      end
      // A result always belongs to an older pass than a request taken now.
      if (out_tvalid && out_tready) begin
        check_result(out_tdata);
        results_seen++;
      end
      if (in_tvalid && in_tready)
        absorb_particle(in_tdata[3*CW-1:0], in_tlast);
    end
    outstanding <= pending_tallies.size();
  end

endmodule

// File: test/periodic_cell_membership_counter_unit_tb.sv
// Testbench top for the periodic cell membership counter unit.
// Drives particle requests, register writes and result back-pressure; checking
// lives in pcmc_result_checker. Depends on pcmc_pkg and the unit's RTL.
`timescale 1ns / 1ps

module periodic_cell_membership_counter_unit_tb;

  localparam int CW = pcmc_pkg::COORD_BITS_DEF;
  localparam int NW = pcmc_pkg::COUNT_BITS_DEF;
  localparam int IN_W = ((3*CW+7)/8)*8;
  localparam int OUT_W = ((2*NW+6*CW+7)/8)*8;
  localparam int IDLE_PCT = 13;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int IDLE_LIMIT = 5000;
  localparam logic [CW-1:0] HALF = {1'b1, {(CW-1){1'b0}}};
  localparam logic [CW-1:0] DEF_CENTER = CW'(1) << (CW-2);
  localparam logic [CW-1:0] DEF_HALF_BUF = CW'((64'd7 << CW) / 20);

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [IN_W-1:0]     in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [OUT_W-1:0]    out_tdata;
  logic                cfg_we;
  pcmc_pkg::cfg_addr_t cfg_addr;
  logic [CW-1:0]       cfg_wdata;
  int                  failures;
  int                  outstanding;

  // Copy of the cell as last programmed, used to aim particles at its edges.
  logic [CW-1:0] ctr [3] = '{DEF_CENTER, DEF_CENTER, DEF_CENTER};
  logic [CW-1:0] hw = DEF_CENTER;
  logic [CW-1:0] hbw = DEF_HALF_BUF;

  bit steady = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  periodic_cell_membership_counter_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pcmc_result_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .failures    (failures),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stalls, or one long hold-off when asked for.
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || $urandom_range(99) >= IDLE_PCT;
      end
    end
  end

  initial begin
    while (quiet_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("watchdog: no request accepted for %0d cycles", IDLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  task automatic send_particle(input logic [CW-1:0] px, py, pz, input bit last);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pz, py, px};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Waits for the unit to go idle, then writes every register, preceded by a
  // write to an unused index that must leave the cell untouched.
  task automatic reconfigure(input logic [CW-1:0] cx, cy, cz, w, bw);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= pcmc_pkg::cfg_addr_t'(pcmc_pkg::REG_HALF_BUFFER_WIDTH + 1 +
                                      $urandom_range(2));
    cfg_wdata <= CW'($urandom);
    @(posedge clk);
    cfg_addr <= pcmc_pkg::REG_CENTER_X;
    cfg_wdata <= cx;
    @(posedge clk);
    cfg_addr <= pcmc_pkg::REG_CENTER_Y;
    cfg_wdata <= cy;
    @(posedge clk);
    cfg_addr <= pcmc_pkg::REG_CENTER_Z;
    cfg_wdata <= cz;
    @(posedge clk);
    cfg_addr <= pcmc_pkg::REG_HALF_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= pcmc_pkg::REG_HALF_BUFFER_WIDTH;
    cfg_wdata <= bw;
    @(posedge clk);
    cfg_we <= 1'b0;
    ctr[0] = cx;
    ctr[1] = cy;
    ctr[2] = cz;
    hw = w;
    hbw = bw;
  endtask

  // Mostly offsets near the main and buffer bounds, near one half or inside the
  // cell; the rest are positions anywhere in the box.
  function automatic logic [CW-1:0] pick_coord(input int a);
    logic [CW-1:0] off;
    case ($urandom_range(9))
      0, 1: return CW'($urandom);
      2: off = hw + CW'($urandom_range(2)) - 1'b1;
      3: off = hbw + CW'($urandom_range(2)) - 1'b1;
      4: off = HALF + CW'($urandom_range(2)) - 1'b1;
      default: off = CW'($urandom_range(hw));
    endcase
    if ($urandom_range(1)) off = -off;
    return ctr[a] + off;
  endfunction

  task automatic run_passes(input int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(8, 1);
      if (len > left) len = left;
      for (int j = 0; j < len; j++)
        send_particle(pick_coord(0), pick_coord(1), pick_coord(2), j == len - 1);
      left -= len;
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= pcmc_pkg::REG_CENTER_X;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed pass at the reset cell: bounds hit exactly and just missed.
    send_particle(ctr[0], ctr[1], ctr[2], 1'b0);
    send_particle(ctr[0] + hw, ctr[1] + hw, ctr[2] + hw, 1'b0);
    send_particle(ctr[0] - hw, ctr[1] - hw, ctr[2] - hw, 1'b0);
    send_particle(ctr[0] + hw + 1'b1, ctr[1], ctr[2], 1'b0);
    send_particle(ctr[0] + hbw - 1'b1, ctr[1] - hbw + 1'b1, ctr[2], 1'b0);
    send_particle(ctr[0], ctr[1], ctr[2] - hbw, 1'b0);
    send_particle(ctr[0] + HALF, ctr[1], ctr[2], 1'b0);
    send_particle('0, '0, '0, 1'b0);
    send_particle('1, '1, '1, 1'b1);
    // A pass with no main particle leaves the box at its cleared values.
    send_particle(ctr[0] + HALF, ctr[1] + HALF, ctr[2] + HALF, 1'b1);
    send_particle(CW'('hAAAAAA), CW'('h555555), CW'('hAAAAAA), 1'b0);
    send_particle(CW'('h555555), CW'('hAAAAAA), CW'('h555555), 1'b1);

    // Zero-sized cell at the origin: only the center itself is main.
    reconfigure('0, '0, '0, '0, '0);
    send_particle('0, '0, '0, 1'b0);
    send_particle(CW'(1), '0, '0, 1'b1);
    run_passes(60);

    // Bounds of one half: everything is main, the half offset is not buffer.
    reconfigure('1, '1, '1, HALF, HALF);
    send_particle(ctr[0] + HALF, ctr[1], ctr[2], 1'b1);
    run_passes(60);

    for (int p = 0; p < 5; p++) begin
      reconfigure(CW'($urandom), CW'($urandom), CW'($urandom),
                  CW'($urandom_range(HALF)), CW'($urandom_range(HALF)));
      case (p)
        1: begin
          steady = 1'b1;
          run_passes(125);
          steady = 1'b0;
        end
        2: begin
          // Results back up while short passes keep arriving.
          hold_req = 1'b1;
          run_passes(125);
        end
        3: begin
          run_passes(60);
          drain_results();
          run_passes(65);
        end
        default: run_passes(125);
      endcase
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
